FILE: rtl/hsr_pkg.sv
// ----------------------------------------------------------------------------
// hsr_pkg
// Shared constants, sector codes and stage payload types for the
// hue/saturation/brightness to RGB converter.
// ----------------------------------------------------------------------------
package hsr_pkg;

  // Number of register stages from input to output register.
  localparam int STAGES = 7;

  localparam int SPAN = 11850;
  localparam int FULL = 255;

  localparam logic [13:0] HUE_SPAN   = 14'(SPAN);
  localparam logic [15:0] HUE_WRAP   = 16'hFFFF;
  localparam logic [7:0]  FULL_SCALE = 8'(FULL);

  // Denominator of the q and t terms, and its reciprocal scaled by 2^RECIP_SHIFT.
  localparam int          RECIP_SHIFT = 40;
  localparam logic [21:0] QT_DEN      = 22'(FULL * SPAN);
  localparam logic [29:0] QT_DEN_W    = 30'(FULL * SPAN);
  localparam logic [18:0] RECIP       =
    19'((64'd1 << RECIP_SHIFT) / 64'(FULL * SPAN));

  localparam logic [15:0] SECTOR_BASE [6] = '{
    16'(0), 16'(SPAN), 16'(2 * SPAN), 16'(3 * SPAN), 16'(4 * SPAN), 16'(5 * SPAN)
  };

  // Sector codes, named by the hue range they cover.
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  typedef logic [STAGES-1:0] stage_vec_t;

  typedef struct packed {
    logic [7:0]  light;
    logic [2:0]  sector;
    logic [13:0] f;
    logic [7:0]  sat;
    logic [7:0]  bri;
    logic [15:0] xp;
  } s1_t;

  typedef struct packed {
    logic [7:0]  light;
    logic [2:0]  sector;
    logic [7:0]  bri;
    logic [21:0] nq;
    logic [21:0] nt;
    logic [15:0] xp;
    logic [7:0]  ep;
  } s2_t;

  typedef struct packed {
    logic [7:0] light;
    logic [2:0] sector;
    logic [7:0] bri;
    logic [7:0] p;
  } ctx_t;

  typedef struct packed {
    ctx_t        ctx;
    logic [29:0] xq;
    logic [29:0] xt;
  } s3_t;

endpackage

FILE: rtl/hsr_sector.sv
// ----------------------------------------------------------------------------
// hsr_sector
// First stage: folds the hue wrap value, splits the hue into sector and
// fraction, and forms the brightness product for the p term.
// ----------------------------------------------------------------------------
module hsr_sector (
  input  logic          clk,
  input  logic          en,
  input  logic [7:0]    light_index,
  input  logic [15:0]   hue,
  input  logic [7:0]    saturation,
  input  logic [7:0]    brightness,
  output hsr_pkg::s1_t  s1
);

  hsr_pkg::s1_t s1_r;
  hsr_pkg::s1_t s1_nxt;
  logic [15:0]  hue_w;
  logic [15:0]  base;
  logic [15:0]  frac;
  logic [2:0]   sec;
  logic [7:0]   sat_c;

  always_comb begin
    hue_w = (hue == hsr_pkg::HUE_WRAP) ? 16'd0 : hue;
    sec   = hsr_pkg::SEC_RY;
    base  = hsr_pkg::SECTOR_BASE[0];
    for (int k = 1; k < 6; k++) begin
      if (hue_w >= hsr_pkg::SECTOR_BASE[k]) begin
        sec  = 3'(k);
        base = hsr_pkg::SECTOR_BASE[k];
      end
    end
    frac  = hue_w - base;
    sat_c = hsr_pkg::FULL_SCALE - saturation;

    s1_nxt.light  = light_index;
    s1_nxt.sector = sec;
    s1_nxt.f      = frac[13:0];
    s1_nxt.sat    = saturation;
    s1_nxt.bri    = brightness;
    s1_nxt.xp     = brightness * sat_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

FILE: rtl/hsr_terms.sv
// ----------------------------------------------------------------------------
// hsr_terms
// Second and third stages: forms the q and t numerators, finishes the p
// term by reciprocal multiply with one correction step, and scales the
// q and t numerators by brightness.
// ----------------------------------------------------------------------------
module hsr_terms (
  input  logic          clk,
  input  logic [1:0]    en,
  input  hsr_pkg::s1_t  s1,
  output hsr_pkg::s3_t  s3
);

  hsr_pkg::s2_t s2_r;
  hsr_pkg::s2_t s2_nxt;
  hsr_pkg::s3_t s3_r;
  hsr_pkg::s3_t s3_nxt;
  logic [13:0]  f_c;
  logic [21:0]  sf_q;
  logic [21:0]  sf_t;
  logic [24:0]  xp257;
  logic [15:0]  ep255;
  logic [15:0]  rem_p;

  always_comb begin
    f_c   = hsr_pkg::HUE_SPAN - s1.f;
    sf_q  = s1.sat * s1.f;
    sf_t  = s1.sat * f_c;
    // Multiplying by 257/65536 undershoots x/255 by less than one.
    xp257 = s1.xp * 9'd257;

    s2_nxt.light  = s1.light;
    s2_nxt.sector = s1.sector;
    s2_nxt.bri    = s1.bri;
    s2_nxt.nq     = hsr_pkg::QT_DEN - sf_q;
    s2_nxt.nt     = hsr_pkg::QT_DEN - sf_t;
    s2_nxt.xp     = s1.xp;
    s2_nxt.ep     = xp257[23:16];
  end

  always_comb begin
    ep255 = s2_r.ep * hsr_pkg::FULL_SCALE;
    rem_p = s2_r.xp - ep255;

    s3_nxt.ctx.light  = s2_r.light;
    s3_nxt.ctx.sector = s2_r.sector;
    s3_nxt.ctx.bri    = s2_r.bri;
    s3_nxt.ctx.p      = s2_r.ep + {7'd0, (rem_p >= {8'd0, hsr_pkg::FULL_SCALE})};
    s3_nxt.xq         = s2_r.bri * s2_r.nq;
    s3_nxt.xt         = s2_r.bri * s2_r.nt;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s2_r <= s2_nxt;
    end
    if (en[1]) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

FILE: rtl/hsr_div.sv
// ----------------------------------------------------------------------------
// hsr_div
// Three-stage floor division of a 30-bit word by 255 * 11850: reciprocal
// multiply, back-multiply, then a single remainder correction.
// ----------------------------------------------------------------------------
module hsr_div (
  input  logic        clk,
  input  logic [2:0]  en,
  input  logic [29:0] num,
  output logic [7:0]  quo
);

  typedef struct packed {
    logic [29:0] x;
    logic [7:0]  e;
  } est_t;

  typedef struct packed {
    logic [29:0] x;
    logic [29:0] es;
    logic [7:0]  e;
  } back_t;

  est_t        est_r;
  est_t        est_nxt;
  back_t       back_r;
  back_t       back_nxt;
  logic [7:0]  quo_r;
  logic [7:0]  quo_nxt;
  logic [48:0] prod;
  logic [29:0] rem;

  always_comb begin
    // The estimate is the true quotient or one below it.
    prod        = num * hsr_pkg::RECIP;
    est_nxt.x   = num;
    est_nxt.e   = prod[47:40];

    back_nxt.x  = est_r.x;
    back_nxt.e  = est_r.e;
    back_nxt.es = est_r.e * hsr_pkg::QT_DEN;

    rem     = back_r.x - back_r.es;
    quo_nxt = back_r.e + {7'd0, (rem >= hsr_pkg::QT_DEN_W)};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      est_r <= est_nxt;
    end
    if (en[1]) begin
      back_r <= back_nxt;
    end
    if (en[2]) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

FILE: rtl/hue_sat_to_rgb.sv
// ----------------------------------------------------------------------------
// hue_sat_to_rgb
// Converts a hue, saturation and brightness word for one light into 8-bit
// red, green and blue levels, with exact floor arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries a light index, a 16-bit
//   hue, an 8-bit saturation and an 8-bit brightness. The result channel
//   (out_valid/out_ready) returns the echoed index and the three levels,
//   one result word for every input word, in order.
//   Throughput is one word per clock when the receiver takes every word;
//   the seven register stages are set by the multiplier chain of the q and
//   t terms (scale, reciprocal multiply, back-multiply and correction).
//   Every stage has its own valid bit and loads whenever it is empty or its
//   successor loads, so bubbles close up and in_ready stays high while any
//   stage is free. When the receiver stalls, the pipeline fills and then
//   in_ready drops; nothing is lost or repeated.
//   A synchronous reset (rst_n low) empties the pipeline by clearing the
//   valid bits; the data and color registers are not reset.
// ----------------------------------------------------------------------------
module hue_sat_to_rgb (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_light_index,
  input  logic [15:0] in_hue,
  input  logic [7:0]  in_saturation,
  input  logic [7:0]  in_brightness,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_light_out,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue
);

  localparam int LAST = hsr_pkg::STAGES - 1;

  hsr_pkg::stage_vec_t valid_r;
  hsr_pkg::stage_vec_t valid_nxt;
  hsr_pkg::stage_vec_t en;
  hsr_pkg::s1_t        s1;
  hsr_pkg::s3_t        s3;
  hsr_pkg::ctx_t       ctx4_r;
  hsr_pkg::ctx_t       ctx5_r;
  hsr_pkg::ctx_t       ctx6_r;
  logic [7:0]          q_val;
  logic [7:0]          t_val;
  logic [7:0]          light_r;
  logic [7:0]          red_r;
  logic [7:0]          green_r;
  logic [7:0]          blue_r;
  logic [7:0]          red_nxt;
  logic [7:0]          green_nxt;
  logic [7:0]          blue_nxt;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[LAST] = !valid_r[LAST] | out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !valid_r[i] | en[i+1];
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int i = 1; i <= LAST; i++) begin
      valid_nxt[i] = en[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  hsr_sector u_sector (
    .clk         (clk),
    .en          (en[0]),
    .light_index (in_light_index),
    .hue         (in_hue),
    .saturation  (in_saturation),
    .brightness  (in_brightness),
    .s1          (s1)
  );

  hsr_terms u_terms (
    .clk (clk),
    .en  (en[2:1]),
    .s1  (s1),
    .s3  (s3)
  );

  hsr_div u_div_q (
    .clk (clk),
    .en  (en[5:3]),
    .num (s3.xq),
    .quo (q_val)
  );

  hsr_div u_div_t (
    .clk (clk),
    .en  (en[5:3]),
    .num (s3.xt),
    .quo (t_val)
  );

  // Side data rides alongside the two dividers.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      ctx4_r <= s3.ctx;
    end
    if (en[4]) begin
      ctx5_r <= ctx4_r;
    end
    if (en[5]) begin
      ctx6_r <= ctx5_r;
    end
  end

  always_comb begin
    case (ctx6_r.sector)
      hsr_pkg::SEC_RY: begin
        red_nxt = ctx6_r.bri; green_nxt = t_val;      blue_nxt = ctx6_r.p;
      end
      hsr_pkg::SEC_YG: begin
        red_nxt = q_val;      green_nxt = ctx6_r.bri; blue_nxt = ctx6_r.p;
      end
      hsr_pkg::SEC_GC: begin
        red_nxt = ctx6_r.p;   green_nxt = ctx6_r.bri; blue_nxt = t_val;
      end
      hsr_pkg::SEC_CB: begin
        red_nxt = ctx6_r.p;   green_nxt = q_val;      blue_nxt = ctx6_r.bri;
      end
      hsr_pkg::SEC_BM: begin
        red_nxt = t_val;      green_nxt = ctx6_r.p;   blue_nxt = ctx6_r.bri;
      end
      default: begin
        red_nxt = ctx6_r.bri; green_nxt = ctx6_r.p;   blue_nxt = q_val;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      light_r <= ctx6_r.light;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = valid_r[LAST];
  assign out_light_out = light_r;
  assign out_red       = red_r;
  assign out_green     = green_r;
  assign out_blue      = blue_r;

  // While any stage is empty the converter must be able to take a word.
  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> in_ready)
    else $error("in_ready low with a free pipeline stage");

  // The p term can never exceed the brightness it was scaled from.
  a_p_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[2] |-> (s3.ctx.p <= s3.ctx.bri))
    else $error("p term above brightness");

  // The corrected quotients stay within brightness as well.
  a_qt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[5] |-> ((q_val <= ctx6_r.bri) && (t_val <= ctx6_r.bri)))
    else $error("q or t term above brightness");

endmodule

FILE: tb/hue_sat_to_rgb_tb.sv
// ----------------------------------------------------------------------------
// hue_sat_to_rgb_tb
// Self-checking bench for the hue/saturation/brightness to RGB converter.
// A queue-fed driver sends directed corner words and then random words
// through four idling phases. A monitor checks every result word in order
// against a bit-exact integer model of the sector and floor arithmetic.
// ----------------------------------------------------------------------------
module hue_sat_to_rgb_tb;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [7:0]  light;
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  bri;
    idle_mode_t  mode;
  } hsb_word_t;

  typedef struct {
    logic [7:0] light;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_word_t;

  localparam int RANDOM_PER_PHASE = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_light_index = '0;
  logic [15:0] in_hue = '0;
  logic [7:0]  in_saturation = '0;
  logic [7:0]  in_brightness = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_light_out;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;

  idle_mode_t  idle_mode = IDLE_NONE;
  hsb_word_t   pending_words[$];
  color_word_t expected_colors[$];
  int          error_count = 0;

  hue_sat_to_rgb DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_light_index(in_light_index),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_light_out (out_light_out),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Exact integer conversion: sector placement of v, p, q and t.
  function automatic color_word_t convert_hsb(logic [7:0] light, logic [15:0] hue,
                                              logic [7:0] sat, logic [7:0] bri);
    longint unsigned h, f, den, v, p, q, t;
    logic [2:0]      sector;
    color_word_t     c;
    h   = hue;
    den = longint'(hsr_pkg::FULL) * hsr_pkg::SPAN;
    if (hue == 16'hFFFF) h = 0;
    sector = 3'(h / hsr_pkg::SPAN);
    f      = h % hsr_pkg::SPAN;
    v = bri;
    p = (bri * (hsr_pkg::FULL - sat)) / hsr_pkg::FULL;
    q = (bri * (den - sat * f)) / den;
    t = (bri * (den - sat * (hsr_pkg::SPAN - f))) / den;
    c.light = light;
    case (sector)
      hsr_pkg::SEC_RY: begin c.red = v[7:0]; c.green = t[7:0]; c.blue = p[7:0]; end
      hsr_pkg::SEC_YG: begin c.red = q[7:0]; c.green = v[7:0]; c.blue = p[7:0]; end
      hsr_pkg::SEC_GC: begin c.red = p[7:0]; c.green = v[7:0]; c.blue = t[7:0]; end
      hsr_pkg::SEC_CB: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = v[7:0]; end
      hsr_pkg::SEC_BM: begin c.red = t[7:0]; c.green = p[7:0]; c.blue = v[7:0]; end
      default:         begin c.red = v[7:0]; c.green = p[7:0]; c.blue = q[7:0]; end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic bit holds_off(idle_mode_t mode, bit sender_side);
    case (mode)
      IDLE_SENDER:   return sender_side && ($urandom_range(99) < 76);
      IDLE_RECEIVER: return !sender_side && ($urandom_range(99) < 76);
      IDLE_BOTH:     return $urandom_range(99) < 11;
      default:       return 1'b0;
    endcase
  endfunction

  task automatic queue_word(logic [7:0] light, logic [15:0] hue, logic [7:0] sat,
                            logic [7:0] bri, idle_mode_t mode);
    hsb_word_t w;
    w.light = light;
    w.hue   = hue;
    w.sat   = sat;
    w.bri   = bri;
    w.mode  = mode;
    pending_words.push_back(w);
  endtask

  // Hues cluster near sector edges and the wrap value part of the time.
  function automatic logic [15:0] random_hue();
    int pick;
    int base;
    pick = $urandom_range(9);
    base = $urandom_range(5) * hsr_pkg::SPAN;
    if (pick < 6) return 16'($urandom);
    if (pick < 9) return 16'(base + $urandom_range(3) - ((base > 0) ? 2 : 0));
    return 16'hFFFF - 16'($urandom_range(1));
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    idle_mode_t mode;
    // Wrap value, sector boundaries and largest fractions.
    queue_word(8'd0,   16'hFFFF, 8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd255, 16'd0,    8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd1,   16'd65534, 8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd2,   16'd11849, 8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd3,   16'd11850, 8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd4,   16'd23699, 8'd200, 8'd255, IDLE_NONE);
    queue_word(8'd5,   16'd23700, 8'd255, 8'd128, IDLE_NONE);
    queue_word(8'd6,   16'd35549, 8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd7,   16'd35550, 8'd128, 8'd255, IDLE_NONE);
    queue_word(8'd8,   16'd47399, 8'd255, 8'd255, IDLE_NONE);
    queue_word(8'd9,   16'd47400, 8'd1,   8'd255, IDLE_NONE);
    queue_word(8'd10,  16'd59249, 8'd255, 8'd254, IDLE_NONE);
    queue_word(8'd11,  16'd59250, 8'd255, 8'd255, IDLE_NONE);
    // Zero saturation gives gray at the brightness level.
    queue_word(8'd12,  16'd30000, 8'd0,   8'd255, IDLE_NONE);
    queue_word(8'd13,  16'hFFFF,  8'd0,   8'd77,  IDLE_NONE);
    queue_word(8'd14,  16'd5925,  8'd0,   8'd0,   IDLE_NONE);
    // Black at full saturation, and mid values.
    queue_word(8'd15,  16'd20000, 8'd255, 8'd0,   IDLE_NONE);
    queue_word(8'd16,  16'd5925,  8'd127, 8'd127, IDLE_NONE);
    queue_word(8'd17,  16'd41475, 8'd254, 8'd1,   IDLE_NONE);
    queue_word(8'd170, 16'hAAAA,  8'hAA,  8'h55,  IDLE_NONE);
    queue_word(8'd85,  16'h5555,  8'h55,  8'hAA,  IDLE_NONE);
    for (int ph = 0; ph < 4; ph++) begin
      mode = idle_mode_t'(ph);
      for (int i = 0; i < RANDOM_PER_PHASE; i++)
        queue_word(8'($urandom), random_hue(), random_level(), random_level(), mode);
    end
  end

  // Driver: predicts each accepted word and presents the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin : drive
      hsb_word_t w;
      if (in_valid && in_ready)
        expected_colors.push_back(convert_hsb(in_light_index, in_hue,
                                              in_saturation, in_brightness));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && !holds_off(pending_words[0].mode, 1'b1)) begin
          w = pending_words.pop_front();
          in_valid       <= 1'b1;
          in_light_index <= w.light;
          in_hue         <= w.hue;
          in_saturation  <= w.sat;
          in_brightness  <= w.bri;
          idle_mode      <= w.mode;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks result words in order and paces out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin : watch
      color_word_t want;
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: result word with no expectation (light %0d)", $time,
                   out_light_out);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (out_light_out !== want.light) report_mismatch("light", out_light_out, want.light);
          if (out_red !== want.red)         report_mismatch("red", out_red, want.red);
          if (out_green !== want.green)     report_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue)       report_mismatch("blue", out_blue, want.blue);
        end
      end
      out_ready <= !holds_off(idle_mode, 1'b0);
    end
  end

  initial begin
    @(posedge rst_n);
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    // Any stray word after the last expected one is caught by the monitor.
    repeat (4 * hsr_pkg::STAGES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
